// File: hdl/assert_macros.svh
// assertion helpers included by the decoder rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hdl/tpfd_pkg.sv
`default_nettype none

package tpfd_pkg;

    localparam int PACKET_BYTES = 6;
    localparam int IDX_W        = $clog2(PACKET_BYTES);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(PACKET_BYTES - 1);

    localparam logic [10:0] Y_FLIP           = 11'd735;
    localparam logic [6:0]  GESTURE_PRESSURE = 7'd80;
    localparam logic [6:0]  STICK_PRESSURE   = 7'd127;
    localparam logic [10:0] DX_LIMIT         = 11'd383;
    localparam logic [11:0] DX_OFFSET        = 12'd768;
    localparam logic [9:0]  DY_LIMIT         = 10'd255;
    localparam logic [10:0] DY_OFFSET        = 11'd512;
    localparam logic [2:0]  WIDTH_FINGER     = 3'd4;
    localparam logic [2:0]  WIDTH_NONE       = 3'd3;

    localparam logic [7:0]  HEADER_VALUE_RST = 8'hF8;
    localparam logic [7:0]  HEADER_MASK_RST  = 8'hF8;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_HEADER_VALUE = 2'd0,
        CFG_HEADER_MASK  = 2'd1,
        CFG_DUAL_POINT   = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_BYTE_TAKEN = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_BAD_HEADER = 2'd2,
        ST_BAD_DATA   = 2'd3
    } t_status;

    // result payload, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [10:0] stick_dy;
        logic [11:0] stick_dx;
        logic        stick_event;
        logic [2:0]  width_code;
        logic [6:0]  pressure;
        logic [10:0] y_position;
        logic [10:0] x_position;
        logic [1:0]  buttons;
    } t_result;

endpackage

`default_nettype wire

// File: hdl/touchpad_packet_framer_decoder.sv
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-----------------------------------
// s (bytes) | in  | i_s_tvalid / o_s_tready      | i_s_tdata[7:0] data_byte
// m (result)| out | o_m_tvalid / i_m_tready      | o_m_tuser status, o_m_tdata fields
// cfg       | in  | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
// one item per cycle while the m side does not stall: each byte gives one result item
// in the cycle after it is taken; the framing compare and the field decode sit between
// the byte port and the result register, so throughput is set by that single result register
// o_s_tready stays high while the result register is empty or being drained,
// so a stall on the m side holds at most one result and then stops the s side
// synchronous active-low reset clears the byte index, the result valid and the
// configuration registers to their defaults; stored packet bytes are not cleared
// o_cfg_ready is always high; writes are expected only while the block is idle
`default_nettype none

`include "assert_macros.svh"

module touchpad_packet_framer_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    // decoded result out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [1:0] buttons, [12:2] x_position, [23:13] y_position, [30:24] pressure,
    // [33:31] width_code, [34] stick_event, [46:35] stick_dx, [57:47] stick_dy,
    // [63:58] zero
    output logic [63:0]      o_m_tdata,
    output logic [1:0]       o_m_tuser,   // [1:0] status
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    // configuration registers
    logic [7:0] r_header_value;
    logic [7:0] r_header_mask;
    logic       r_dual_point;

    // framing state and stored packet bytes 1..4 (byte 0 is only checked,
    // byte 5 is decoded straight from the port)
    logic [tpfd_pkg::IDX_W-1:0] r_index, n_index;
    logic [7:0] r_byte1, r_byte2, r_byte3, r_byte4;

    // result register
    logic               r_out_valid;
    tpfd_pkg::t_status  r_status, n_status;
    tpfd_pkg::t_result  r_result, n_result;

    logic                       s_accept;
    logic                       cfg_accept;
    logic [tpfd_pkg::IDX_W-1:0] idx;
    logic                       bad_header;
    logic                       bad_data;
    logic                       last_byte;

    // decode terms
    logic [10:0] x_raw;
    logic [9:0]  y_raw;
    logic [6:0]  press;
    logic        stick;

    assign o_s_tready  = !r_out_valid || i_m_tready;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid;

    // an out-of-range index counts as the start of a packet
    assign idx = (r_index > tpfd_pkg::LAST_INDEX) ? '0 : r_index;

    assign bad_header = (idx == '0) && ((i_s_tdata & r_header_mask) != r_header_value);
    assign bad_data   = (idx > tpfd_pkg::IDX_W'(1)) && i_s_tdata[7];
    assign last_byte  = (idx == tpfd_pkg::LAST_INDEX);

    // byte1 bit 7 and byte2 bit 3 both land on x bit 7
    assign x_raw = {r_byte2[6:4], r_byte2[3] | r_byte1[7], r_byte1[6:0]};
    assign y_raw = {r_byte3[6:5], r_byte3[4] | r_byte4[7], r_byte4[6:0]};
    assign press = r_byte2[0] ? tpfd_pkg::GESTURE_PRESSURE : i_s_tdata[6:0];
    assign stick = r_dual_point && (press == tpfd_pkg::STICK_PRESSURE);

    always_comb begin
        n_result = '0;
        n_status = tpfd_pkg::ST_BYTE_TAKEN;
        n_index  = idx + tpfd_pkg::IDX_W'(1);
        if (bad_header) begin
            n_status = tpfd_pkg::ST_BAD_HEADER;
            n_index  = '0;
        end else if (bad_data) begin
            n_status = tpfd_pkg::ST_BAD_DATA;
            n_index  = '0;
        end else if (last_byte) begin
            n_status            = tpfd_pkg::ST_COMPLETE;
            n_index             = '0;
            n_result.buttons    = r_byte3[1:0];
            n_result.x_position = x_raw;
            n_result.y_position = tpfd_pkg::Y_FLIP - {1'b0, y_raw};
            n_result.pressure   = press;
            n_result.width_code = (r_byte2[1] || r_byte2[0]) ? tpfd_pkg::WIDTH_FINGER
                                                             : tpfd_pkg::WIDTH_NONE;
            if (stick) begin
                n_result.stick_event = 1'b1;
                n_result.stick_dx    = (x_raw > tpfd_pkg::DX_LIMIT)
                                       ? ({1'b0, x_raw} - tpfd_pkg::DX_OFFSET)
                                       : {1'b0, x_raw};
                n_result.stick_dy    = (y_raw > tpfd_pkg::DY_LIMIT)
                                       ? ({1'b0, y_raw} - tpfd_pkg::DY_OFFSET)
                                       : {1'b0, y_raw};
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_accept) begin
                r_index <= n_index;
            end
            if (s_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value <= tpfd_pkg::HEADER_VALUE_RST;
            r_header_mask  <= tpfd_pkg::HEADER_MASK_RST;
            r_dual_point   <= 1'b0;
        end else if (cfg_accept) begin
            case (i_cfg_index)
                tpfd_pkg::CFG_HEADER_VALUE: r_header_value <= i_cfg_data;
                tpfd_pkg::CFG_HEADER_MASK:  r_header_mask  <= i_cfg_data;
                tpfd_pkg::CFG_DUAL_POINT:   r_dual_point   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // payload: packet bytes and result
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_status <= n_status;
            r_result <= n_result;
            if (!bad_data) begin
                case (idx)
                    tpfd_pkg::IDX_W'(1): r_byte1 <= i_s_tdata;
                    tpfd_pkg::IDX_W'(2): r_byte2 <= i_s_tdata;
                    tpfd_pkg::IDX_W'(3): r_byte3 <= i_s_tdata;
                    tpfd_pkg::IDX_W'(4): r_byte4 <= i_s_tdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = r_result;

    // index never leaves the packet
    `ASSERT_CLK(a_index_range, i_clk, i_rst_n, r_index <= tpfd_pkg::LAST_INDEX)

    // any result other than a complete packet carries all-zero fields
    `ASSERT_CLK(a_zero_fields, i_clk, i_rst_n,
        (r_out_valid && (r_status != tpfd_pkg::ST_COMPLETE)) |-> (r_result == '0))

    // a stick event only comes with dual point on and full pressure
    `ASSERT_CLK(a_stick_event, i_clk, i_rst_n,
        (r_out_valid && r_result.stick_event) |->
        (r_dual_point && (r_result.pressure == tpfd_pkg::STICK_PRESSURE)))

    // a completed packet or an error restarts framing
    `ASSERT_CLK(a_restart, i_clk, i_rst_n,
        (s_accept && (n_status != tpfd_pkg::ST_BYTE_TAKEN)) |=> (r_index == '0))

    // reset empties the result register
    `ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !r_out_valid)

endmodule

`default_nettype wire
